// File: hdl/rdq_pkg.sv
// Package for the record deque unit.
// Holds the record type, action and status codes and default sizes.
// No dependencies.
package rdq_pkg;

  localparam int DEPTH_DEF      = 64;
  localparam int TEXT_CHARS_DEF = 8;
  localparam int TEXT_W         = 64;
  localparam int PAY_W          = 31;
  localparam int PHONE_W        = 50;
  localparam int ENTRIES_W      = 7;

  localparam logic [2:0] ACT_PUSH_BACK  = 3'd0;
  localparam logic [2:0] ACT_POP_BACK   = 3'd1;
  localparam logic [2:0] ACT_PUSH_FRONT = 3'd2;
  localparam logic [2:0] ACT_POP_FRONT  = 3'd3;
  localparam logic [2:0] ACT_LIST_ALL   = 3'd4;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic [TEXT_W-1:0]  key;
    logic [TEXT_W-1:0]  person;
    logic [TEXT_W-1:0]  group;
    logic [TEXT_W-1:0]  role;
    logic [PAY_W-1:0]   pay;
    logic [PHONE_W-1:0] phone;
  } record_t;

endpackage

// File: hdl/record_deque_unit.sv
// Top level of the record deque unit: a ring of records in one memory.
// Depends on rdq_pkg.
//
// A double-ended queue of up to DEPTH records. An item is taken when start
// is high and busy is low. A push or pop gives its single result on the
// cycle after acceptance, marked by done. List all holds busy high and
// streams one record per cycle, front first, a rate set by the single
// memory read port. Results cannot be held off, so they must be taken in
// the cycle in which done is high. Unused action codes are taken and give
// no result.
module record_deque_unit #(
  parameter int DEPTH      = rdq_pkg::DEPTH_DEF,
  parameter int TEXT_CHARS = rdq_pkg::TEXT_CHARS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [2:0]                    action,
  input  logic [rdq_pkg::TEXT_W-1:0]    key_text,
  input  logic [rdq_pkg::TEXT_W-1:0]    person_text,
  input  logic [rdq_pkg::TEXT_W-1:0]    group_text,
  input  logic [rdq_pkg::TEXT_W-1:0]    role_text,
  input  logic [rdq_pkg::PAY_W-1:0]     pay,
  input  logic [rdq_pkg::PHONE_W-1:0]   phone_number,
  output logic                          done,
  output logic [1:0]                    status,
  output logic [rdq_pkg::TEXT_W-1:0]    out_key,
  output logic [rdq_pkg::TEXT_W-1:0]    out_person,
  output logic [rdq_pkg::TEXT_W-1:0]    out_group,
  output logic [rdq_pkg::TEXT_W-1:0]    out_role,
  output logic [rdq_pkg::PAY_W-1:0]     out_pay,
  output logic [rdq_pkg::PHONE_W-1:0]   out_phone,
  output logic [rdq_pkg::ENTRIES_W-1:0] entries,
  output logic                          last
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = IW + 1;
  localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
  localparam logic [IW-1:0] TOP_IDX = IW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam logic [rdq_pkg::TEXT_W-1:0] TEXT_MASK =
    {rdq_pkg::TEXT_W{1'b1}} >> (rdq_pkg::TEXT_W - 8 * TEXT_CHARS);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_LIST = 1'b1;

  rdq_pkg::record_t mem [DEPTH];
  rdq_pkg::record_t rd_data;
  rdq_pkg::record_t wr_data;

  logic          state, state_next;
  logic [IW-1:0] front, front_next;
  logic [CW-1:0] count, count_next;
  logic [IW-1:0] list_ptr, list_ptr_next;
  logic [CW-1:0] list_left, list_left_next;
  logic          done_next;
  logic [1:0]    res_status, res_status_next;
  logic          res_key, res_key_next;
  logic          res_full, res_full_next;
  logic [CW-1:0] res_entries, res_entries_next;
  logic          res_last, res_last_next;

  logic          rd_en, wr_en;
  logic [IW-1:0] rd_addr, wr_addr;
  logic [SW-1:0] back_sum, last_sum;
  logic [IW-1:0] back_slot, last_slot, front_inc, front_dec, ptr_inc;

  assign busy = (state == ST_LIST);

  assign back_sum  = SW'(front) + SW'(count);
  assign last_sum  = SW'(front) + SW'(count) - SW'(1);
  assign back_slot = (back_sum >= DEPTH_S) ? IW'(back_sum - DEPTH_S) : IW'(back_sum);
  assign last_slot = (last_sum >= DEPTH_S) ? IW'(last_sum - DEPTH_S) : IW'(last_sum);
  assign front_inc = (front == TOP_IDX) ? '0 : front + IW'(1);
  assign front_dec = (front == '0) ? TOP_IDX : front - IW'(1);
  assign ptr_inc   = (list_ptr == TOP_IDX) ? '0 : list_ptr + IW'(1);

  assign wr_data.key    = key_text & TEXT_MASK;
  assign wr_data.person = person_text & TEXT_MASK;
  assign wr_data.group  = group_text & TEXT_MASK;
  assign wr_data.role   = role_text & TEXT_MASK;
  assign wr_data.pay    = pay;
  assign wr_data.phone  = phone_number;

  always_comb begin
    state_next       = state;
    front_next       = front;
    count_next       = count;
    list_ptr_next    = list_ptr;
    list_left_next   = list_left;
    done_next        = 1'b0;
    res_status_next  = rdq_pkg::STAT_OK;
    res_key_next     = 1'b0;
    res_full_next    = 1'b0;
    res_entries_next = count;
    res_last_next    = 1'b1;
    rd_en            = 1'b0;
    rd_addr          = list_ptr;
    wr_en            = 1'b0;
    wr_addr          = back_slot;
    if (state == ST_LIST) begin
      rd_en          = 1'b1;
      rd_addr        = list_ptr;
      list_ptr_next  = ptr_inc;
      list_left_next = list_left - CW'(1);
      done_next      = 1'b1;
      res_full_next  = 1'b1;
      res_last_next  = (list_left == CW'(1));
      if (list_left == CW'(1)) begin
        state_next = ST_IDLE;
      end
    end else if (start) begin
      case (action)
        rdq_pkg::ACT_PUSH_BACK, rdq_pkg::ACT_PUSH_FRONT: begin
          done_next = 1'b1;
          if (count == FULL_CNT) begin
            res_status_next = rdq_pkg::STAT_FULL;
          end else begin
            wr_en            = 1'b1;
            count_next       = count + CW'(1);
            res_entries_next = count + CW'(1);
            if (action == rdq_pkg::ACT_PUSH_FRONT) begin
              wr_addr    = front_dec;
              front_next = front_dec;
            end
          end
        end
        rdq_pkg::ACT_POP_BACK, rdq_pkg::ACT_POP_FRONT: begin
          done_next = 1'b1;
          if (count == '0) begin
            res_status_next = rdq_pkg::STAT_EMPTY;
          end else begin
            rd_en            = 1'b1;
            res_key_next     = 1'b1;
            count_next       = count - CW'(1);
            res_entries_next = count - CW'(1);
            if (action == rdq_pkg::ACT_POP_BACK) begin
              rd_addr = last_slot;
            end else begin
              rd_addr    = front;
              front_next = front_inc;
            end
          end
        end
        rdq_pkg::ACT_LIST_ALL: begin
          done_next = 1'b1;
          if (count == '0) begin
            res_status_next = rdq_pkg::STAT_EMPTY;
          end else begin
            rd_en          = 1'b1;
            rd_addr        = front;
            res_full_next  = 1'b1;
            list_ptr_next  = front_inc;
            list_left_next = count - CW'(1);
            res_last_next  = (count == CW'(1));
            if (count != CW'(1)) begin
              state_next = ST_LIST;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      front <= '0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      front <= front_next;
      count <= count_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    list_ptr    <= list_ptr_next;
    list_left   <= list_left_next;
    res_status  <= res_status_next;
    res_key     <= res_key_next;
    res_full    <= res_full_next;
    res_entries <= res_entries_next;
    res_last    <= res_last_next;
  end

  assign status     = res_status;
  assign out_key    = (res_key || res_full) ? rd_data.key : '0;
  assign out_person = res_full ? rd_data.person : '0;
  assign out_group  = res_full ? rd_data.group : '0;
  assign out_role   = res_full ? rd_data.role : '0;
  assign out_pay    = res_full ? rd_data.pay : '0;
  assign out_phone  = res_full ? rd_data.phone : '0;
  assign entries    = rdq_pkg::ENTRIES_W'(res_entries);
  assign last       = res_last;

  a_mid_list_busy: assert property (@(posedge clk) disable iff (rst)
    (done && !last) |-> busy)
    else $error("non-final result outside a listing");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("record count beyond depth");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (done && status == rdq_pkg::STAT_FULL) |-> (res_entries == FULL_CNT))
    else $error("full reported with free space");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    (done && status == rdq_pkg::STAT_EMPTY) |-> (res_entries == '0 && last))
    else $error("empty reported with records held");

endmodule

// File: bench/record_deque_checker.sv
// Checker for the record deque unit: watches the item and result ports, keeps
// its own copy of the deque and compares every result with the one expected.
// Depends on rdq_pkg.
`timescale 1ns / 100ps

module record_deque_checker #(
  parameter int DEPTH      = rdq_pkg::DEPTH_DEF,
  parameter int TEXT_CHARS = rdq_pkg::TEXT_CHARS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  logic [2:0]                    action,
  input  logic [rdq_pkg::TEXT_W-1:0]    key_text,
  input  logic [rdq_pkg::TEXT_W-1:0]    person_text,
  input  logic [rdq_pkg::TEXT_W-1:0]    group_text,
  input  logic [rdq_pkg::TEXT_W-1:0]    role_text,
  input  logic [rdq_pkg::PAY_W-1:0]     pay,
  input  logic [rdq_pkg::PHONE_W-1:0]   phone_number,
  input  logic                          done,
  input  logic [1:0]                    status,
  input  logic [rdq_pkg::TEXT_W-1:0]    out_key,
  input  logic [rdq_pkg::TEXT_W-1:0]    out_person,
  input  logic [rdq_pkg::TEXT_W-1:0]    out_group,
  input  logic [rdq_pkg::TEXT_W-1:0]    out_role,
  input  logic [rdq_pkg::PAY_W-1:0]     out_pay,
  input  logic [rdq_pkg::PHONE_W-1:0]   out_phone,
  input  logic [rdq_pkg::ENTRIES_W-1:0] entries,
  input  logic                          last,
  output int                            errors,
  output int                            pending,
  output int                            fill_level
);

  localparam logic [rdq_pkg::TEXT_W-1:0] TEXT_MASK =
    (TEXT_CHARS >= 8) ? {rdq_pkg::TEXT_W{1'b1}} :
                        ((64'd1 << (8 * TEXT_CHARS)) - 64'd1);

  typedef struct packed {
    logic [1:0]                    status;
    rdq_pkg::record_t              rec;
    logic [rdq_pkg::ENTRIES_W-1:0] entries;
    logic                          last;
  } deque_reply_t;

  rdq_pkg::record_t ring [DEPTH];
  deque_reply_t     awaited [$];
  int               front;

  initial begin
    errors = 0;
    pending = 0;
    fill_level = 0;
    front = 0;
  end

  always @(posedge clk) begin
    deque_reply_t     seen;
    deque_reply_t     want;
    rdq_pkg::record_t incoming;
    int               slot;
    if (rst) begin
      front = 0;
      fill_level = 0;
      awaited.delete();
    end else begin
      if (done) begin
        seen = {status, out_key, out_person, out_group, out_role, out_pay, out_phone,
                entries, last};
        if (awaited.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: result with nothing expected: st=%0d key=%h n=%0d last=%b",
                     $realtime, seen.status, seen.rec.key, seen.entries, seen.last);
        end else begin
          want = awaited.pop_front();
          if (seen.status !== want.status || seen.rec.key !== want.rec.key ||
              seen.rec.person !== want.rec.person || seen.rec.group !== want.rec.group ||
              seen.rec.role !== want.rec.role || seen.rec.pay !== want.rec.pay ||
              seen.rec.phone !== want.rec.phone || seen.entries !== want.entries ||
              seen.last !== want.last) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: expected st=%0d key=%h per=%h grp=%h rol=%h pay=%h ph=%h n=%0d l=%b",
                       $realtime, want.status, want.rec.key, want.rec.person,
                       want.rec.group, want.rec.role, want.rec.pay, want.rec.phone,
                       want.entries, want.last);
              $display("%0t: actual   st=%0d key=%h per=%h grp=%h rol=%h pay=%h ph=%h n=%0d l=%b",
                       $realtime, seen.status, seen.rec.key, seen.rec.person,
                       seen.rec.group, seen.rec.role, seen.rec.pay, seen.rec.phone,
                       seen.entries, seen.last);
            end
          end
        end
      end

      if (start && !busy) begin
        incoming = {key_text & TEXT_MASK, person_text & TEXT_MASK, group_text & TEXT_MASK,
                    role_text & TEXT_MASK, pay, phone_number};
        want = '0;
        want.last = 1'b1;
        case (action)
          rdq_pkg::ACT_PUSH_BACK, rdq_pkg::ACT_PUSH_FRONT: begin
            if (fill_level == DEPTH) begin
              want.status = rdq_pkg::STAT_FULL;
            end else begin
              if (action == rdq_pkg::ACT_PUSH_FRONT) begin
                front = (front + DEPTH - 1) % DEPTH;
                slot = front;
              end else begin
                slot = (front + fill_level) % DEPTH;
              end
              ring[slot] = incoming;
              fill_level++;
              want.status = rdq_pkg::STAT_OK;
            end
            want.entries = rdq_pkg::ENTRIES_W'(fill_level);
            awaited.push_back(want);
          end
          rdq_pkg::ACT_POP_BACK, rdq_pkg::ACT_POP_FRONT: begin
            if (fill_level == 0) begin
              want.status = rdq_pkg::STAT_EMPTY;
            end else begin
              if (action == rdq_pkg::ACT_POP_BACK) begin
                slot = (front + fill_level - 1) % DEPTH;
              end else begin
                slot = front;
                front = (front + 1) % DEPTH;
              end
              fill_level--;
              want.status = rdq_pkg::STAT_OK;
              want.rec.key = ring[slot].key;
            end
            want.entries = rdq_pkg::ENTRIES_W'(fill_level);
            awaited.push_back(want);
          end
          rdq_pkg::ACT_LIST_ALL: begin
            if (fill_level == 0) begin
              want.status = rdq_pkg::STAT_EMPTY;
              awaited.push_back(want);
            end else begin
              for (int i = 0; i < fill_level; i++) begin
                want.status = rdq_pkg::STAT_OK;
                want.rec = ring[(front + i) % DEPTH];
                want.entries = rdq_pkg::ENTRIES_W'(fill_level);
                want.last = (i == fill_level - 1);
                awaited.push_back(want);
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
    pending = awaited.size();
  end

endmodule

// File: bench/record_deque_unit_tb.sv
// Top of the record deque unit testbench: clock, reset, item stimulus and the
// final verdict. Depends on rdq_pkg, record_deque_unit and record_deque_checker.
`timescale 1ns / 100ps

module record_deque_unit_tb;

  localparam int DEPTH        = rdq_pkg::DEPTH_DEF;
  localparam int TEXT_CHARS   = rdq_pkg::TEXT_CHARS_DEF;
  localparam int GAP_MAX      = 15;
  localparam int RANDOM_ITEMS = 300;
  localparam int STALL_LIMIT  = 2000;
  localparam logic [rdq_pkg::PHONE_W-1:0] PHONE_TOP = 50'd999999999999999;

  typedef enum logic [1:0] {MODE_FILL, MODE_DRAIN, MODE_MIX} phase_t;

  logic                          clk;
  logic                          rst;
  logic                          start;
  logic                          busy;
  logic [2:0]                    action;
  rdq_pkg::record_t              item_rec;
  logic                          done;
  logic [1:0]                    status;
  logic [rdq_pkg::TEXT_W-1:0]    out_key;
  logic [rdq_pkg::TEXT_W-1:0]    out_person;
  logic [rdq_pkg::TEXT_W-1:0]    out_group;
  logic [rdq_pkg::TEXT_W-1:0]    out_role;
  logic [rdq_pkg::PAY_W-1:0]     out_pay;
  logic [rdq_pkg::PHONE_W-1:0]   out_phone;
  logic [rdq_pkg::ENTRIES_W-1:0] entries;
  logic                          last;
  int                            errors;
  int                            pending;
  int                            fill_level;
  int                            idle_cycles = 0;
  bit                            no_gaps;

  record_deque_unit #(
    .DEPTH(DEPTH),
    .TEXT_CHARS(TEXT_CHARS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .action(action),
    .key_text(item_rec.key),
    .person_text(item_rec.person),
    .group_text(item_rec.group),
    .role_text(item_rec.role),
    .pay(item_rec.pay),
    .phone_number(item_rec.phone),
    .done(done),
    .status(status),
    .out_key(out_key),
    .out_person(out_person),
    .out_group(out_group),
    .out_role(out_role),
    .out_pay(out_pay),
    .out_phone(out_phone),
    .entries(entries),
    .last(last)
  );

  record_deque_checker #(
    .DEPTH(DEPTH),
    .TEXT_CHARS(TEXT_CHARS)
  ) u_check (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .action(action),
    .key_text(item_rec.key),
    .person_text(item_rec.person),
    .group_text(item_rec.group),
    .role_text(item_rec.role),
    .pay(item_rec.pay),
    .phone_number(item_rec.phone),
    .done(done),
    .status(status),
    .out_key(out_key),
    .out_person(out_person),
    .out_group(out_group),
    .out_role(out_role),
    .out_pay(out_pay),
    .out_phone(out_phone),
    .entries(entries),
    .last(last),
    .errors(errors),
    .pending(pending),
    .fill_level(fill_level)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic rdq_pkg::record_t any_record();
    rdq_pkg::record_t r;
    logic [63:0]      ph;
    r.key = {$urandom, $urandom};
    r.person = {$urandom, $urandom};
    r.group = {$urandom, $urandom};
    r.role = {$urandom, $urandom};
    r.pay = rdq_pkg::PAY_W'($urandom);
    ph = {$urandom, $urandom};
    r.phone = ph[rdq_pkg::PHONE_W-1:0];
    if (r.phone > PHONE_TOP)
      r.phone = r.phone - PHONE_TOP - 1;
    case ($urandom_range(0, 9))
      0: r = '0;
      1: begin
        r = '1;
        r.phone = PHONE_TOP;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic issue(input logic [2:0] act, input rdq_pkg::record_t rec);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, GAP_MAX);
    if ($urandom_range(0, 19) == 0)
      no_gaps = !no_gaps;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    action <= act;
    item_rec <= rec;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  initial begin
    rdq_pkg::record_t ones_rec;
    rdq_pkg::record_t text_rec;
    phase_t           phase;
    int               sent;
    int               over;
    int               run;
    logic [2:0]       act;
    rst = 1'b1;
    start = 1'b0;
    action = rdq_pkg::ACT_PUSH_BACK;
    item_rec = '0;
    no_gaps = 1'b0;
    ones_rec = '1;
    ones_rec.phone = PHONE_TOP;
    text_rec = any_record();
    text_rec.key = "EMP00042";
    text_rec.person = "NAME0001";
    text_rec.group = rdq_pkg::TEXT_W'("FINANCE");
    text_rec.role = rdq_pkg::TEXT_W'("ANALYST");
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Empty deque first, then both ends, the extremes and the unused codes.
    issue(rdq_pkg::ACT_LIST_ALL, any_record());
    issue(rdq_pkg::ACT_POP_BACK, any_record());
    issue(rdq_pkg::ACT_POP_FRONT, any_record());
    issue(rdq_pkg::ACT_PUSH_BACK, ones_rec);
    issue(rdq_pkg::ACT_PUSH_FRONT, '0);
    issue(rdq_pkg::ACT_PUSH_BACK, text_rec);
    issue(rdq_pkg::ACT_LIST_ALL, any_record());
    for (int k = 1; k <= 3; k++)
      issue(3'(rdq_pkg::ACT_LIST_ALL + k), ones_rec);
    issue(rdq_pkg::ACT_POP_FRONT, any_record());
    issue(rdq_pkg::ACT_POP_BACK, any_record());
    issue(rdq_pkg::ACT_PUSH_FRONT, any_record());
    issue(rdq_pkg::ACT_POP_BACK, any_record());
    issue(rdq_pkg::ACT_POP_FRONT, any_record());
    issue(rdq_pkg::ACT_POP_FRONT, any_record());
    issue(rdq_pkg::ACT_PUSH_FRONT, any_record());
    issue(rdq_pkg::ACT_PUSH_FRONT, any_record());
    issue(rdq_pkg::ACT_LIST_ALL, any_record());
    issue(rdq_pkg::ACT_POP_BACK, any_record());
    issue(rdq_pkg::ACT_POP_BACK, any_record());
    issue(rdq_pkg::ACT_LIST_ALL, any_record());

    // Fill to beyond full, drain to beyond empty, then a mixed run, repeated.
    phase = MODE_FILL;
    sent = 0;
    over = 0;
    run = 0;
    while (sent < RANDOM_ITEMS) begin
      case (phase)
        MODE_FILL: begin
          if (fill_level == DEPTH)
            over++;
          if ($urandom_range(0, 9) == 0)
            act = rdq_pkg::ACT_LIST_ALL;
          else
            act = $urandom_range(0, 1) ? rdq_pkg::ACT_PUSH_FRONT : rdq_pkg::ACT_PUSH_BACK;
          if (over > 3) begin
            phase = MODE_DRAIN;
            over = 0;
          end
        end
        MODE_DRAIN: begin
          if (fill_level == 0)
            over++;
          if ($urandom_range(0, 9) == 0)
            act = rdq_pkg::ACT_LIST_ALL;
          else
            act = $urandom_range(0, 1) ? rdq_pkg::ACT_POP_FRONT : rdq_pkg::ACT_POP_BACK;
          if (over > 2) begin
            phase = MODE_MIX;
            over = 0;
            run = $urandom_range(30, 60);
          end
        end
        default: begin
          if ($urandom_range(0, 19) == 0)
            act = 3'(rdq_pkg::ACT_LIST_ALL + $urandom_range(1, 3));
          else
            act = 3'($urandom_range(rdq_pkg::ACT_PUSH_BACK, rdq_pkg::ACT_LIST_ALL));
          run--;
          if (run <= 0)
            phase = MODE_FILL;
        end
      endcase
      issue(act, any_record());
      if (act <= rdq_pkg::ACT_LIST_ALL)
        sent++;
    end

    start <= 1'b0;
    wait (pending == 0);
    repeat (8) @(posedge clk);
    if (errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: filelist.f
hdl/rdq_pkg.sv
hdl/record_deque_unit.sv
bench/record_deque_checker.sv
bench/record_deque_unit_tb.sv
